// ----- design/bdq_pkg.sv -----
package bdq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int ENTRY_W   = 7;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [ENTRY_W-1:0]       t_entry;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // shift and write controls broadcast to every cell
    typedef struct packed {
        logic f_ins;
        logic f_del;
        logic f_put;
        logic r_ins;
        logic r_del;
        logic r_put;
    } t_cell_ctl;

    typedef struct packed {
        t_word   popped_value;
        t_status status;
        t_entry  entry_count;
        logic    is_empty;
        t_word   front_word;
        t_word   back_word;
    } t_result;

endpackage

// ----- design/bdq_in_if.sv -----
interface bdq_in_if;
    import bdq_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_word data_value;

    modport source (output valid, output kind, output data_value, input ready);
    modport sink (input valid, input kind, input data_value, output ready);
endinterface

// ----- design/bdq_out_if.sv -----
interface bdq_out_if;
    import bdq_pkg::*;

    logic    valid;
    logic    ready;
    t_word   popped_value;
    t_status status;
    t_entry  entry_count;
    logic    is_empty;
    t_word   front_word;
    t_word   back_word;

    modport source (
        output valid, output popped_value, output status, output entry_count,
        output is_empty, output front_word, output back_word, input ready
    );
    modport sink (
        input valid, input popped_value, input status, input entry_count,
        input is_empty, input front_word, input back_word, output ready
    );
endinterface

// ----- design/bdq_cell.sv -----
module bdq_cell #(
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  bdq_pkg::t_word      i_f_left,
    input  bdq_pkg::t_word      i_f_right,
    input  bdq_pkg::t_word      i_r_left,
    input  bdq_pkg::t_word      i_r_right,
    input  bdq_pkg::t_word      i_data,
    input  bdq_pkg::t_cell_ctl  i_ctl,
    input  logic [CNT_W-1:0]    i_put_idx,
    output bdq_pkg::t_word      o_f,
    output bdq_pkg::t_word      o_r
);
    import bdq_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

    t_word r_f, n_f;
    t_word r_r, n_r;
    logic  w_hit;

    assign w_hit = (i_put_idx == MY_IDX);

    always_comb begin
        n_f = r_f;
        if (i_ctl.f_ins) begin
            n_f = i_f_left;
        end else if (i_ctl.f_del) begin
            n_f = i_f_right;
        end else if (i_ctl.f_put && w_hit) begin
            n_f = i_data;
        end
    end

    always_comb begin
        n_r = r_r;
        if (i_ctl.r_ins) begin
            n_r = i_r_left;
        end else if (i_ctl.r_del) begin
            n_r = i_r_right;
        end else if (i_ctl.r_put && w_hit) begin
            n_r = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
        r_r <= n_r;
    end

    assign o_f = r_f;
    assign o_r = r_r;
endmodule

// ----- design/bounded_double_ended_queue_top.sv -----
// Bounded double-ended queue of signed 32-bit words, up to DEPTH entries.
// One transaction per cycle is accepted while the skid register is free, each
// giving exactly one result via an output register backed by a skid register,
// so the input stays open while one result waits and closes only when both hold
// results. Storage is a row of DEPTH identical cells that shift in both
// directions. Each cell holds two words: one row keeps the queue in order
// with the front in cell 0, the other keeps it reversed with the back in
// cell 0. A push at one end shifts that end's row and writes the word into
// the other row at position count; a pop shifts its own row and just drops
// the last valid entry of the other. Front, back and popped words therefore
// always come from fixed cells. A push on a full queue is refused with
// status 1, a pop on an empty queue returns zero with status 2; peeks read
// zero when the queue is empty. Cell contents are not reset; only occupied
// cells are ever read.
module bounded_double_ended_queue_top #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bdq_in_if.sink           i_in,
    bdq_out_if.source        o_out
);
    import bdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    // cell outputs: forward row and reversed row
    t_word w_f [DEPTH];
    t_word w_r [DEPTH];

    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cell_ctl        w_ctl;
    t_result          w_res;
    logic             w_acc, w_take;
    logic             w_full, w_empty;
    t_kind            w_kind;
    t_word            w_front, w_back;

    logic    r_out_vld, r_skid_vld;
    t_result r_out_res, r_skid_res;

    assign w_kind  = i_in.kind;
    assign w_full  = (r_cnt == FULL_CNT);
    assign w_empty = (r_cnt == '0);

    assign i_in.ready = !r_skid_vld;
    assign w_acc      = i_in.valid && !r_skid_vld;
    assign w_take     = r_out_vld && o_out.ready;

    // decode the transaction into cell controls, next count and the result
    always_comb begin
        w_ctl   = '0;
        n_cnt   = r_cnt;
        w_front = w_f[0];
        w_back  = w_r[0];
        w_res   = '0;
        w_res.status = ST_DONE;
        case (w_kind)
            KIND_PUSH_FRONT: begin
                if (w_full) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_ctl.f_ins = 1'b1;
                    w_ctl.r_put = 1'b1;
                    n_cnt   = r_cnt + ONE_CNT;
                    w_front = i_in.data_value;
                    if (w_empty) begin
                        w_back = i_in.data_value;
                    end
                end
            end
            KIND_PUSH_BACK: begin
                if (w_full) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_ctl.r_ins = 1'b1;
                    w_ctl.f_put = 1'b1;
                    n_cnt  = r_cnt + ONE_CNT;
                    w_back = i_in.data_value;
                    if (w_empty) begin
                        w_front = i_in.data_value;
                    end
                end
            end
            KIND_POP_FRONT: begin
                if (w_empty) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    w_ctl.f_del = 1'b1;
                    n_cnt   = r_cnt - ONE_CNT;
                    w_res.popped_value = w_f[0];
                    w_front = w_f[1];
                end
            end
            KIND_POP_BACK: begin
                if (w_empty) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    w_ctl.r_del = 1'b1;
                    n_cnt  = r_cnt - ONE_CNT;
                    w_res.popped_value = w_r[0];
                    w_back = w_r[1];
                end
            end
            default: begin
                w_res.status = ST_DONE;
            end
        endcase
        if (!w_acc) begin
            w_ctl = '0;
            n_cnt = r_cnt;
        end
        w_res.entry_count = ENTRY_W'(n_cnt);
        w_res.is_empty    = (n_cnt == '0);
        w_res.front_word  = (n_cnt == '0) ? t_word'(0) : w_front;
        w_res.back_word   = (n_cnt == '0) ? t_word'(0) : w_back;
    end

    // row of cells; the pushed word enters at the left of cell 0, the last
    // cell feeds itself back on a delete
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_word w_fl, w_fr, w_rl, w_rr;
        if (gi == 0) begin : g_head
            assign w_fl = i_in.data_value;
            assign w_rl = i_in.data_value;
        end else begin : g_body
            assign w_fl = w_f[gi-1];
            assign w_rl = w_r[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_tail
            assign w_fr = w_f[gi];
            assign w_rr = w_r[gi];
        end else begin : g_inner
            assign w_fr = w_f[gi+1];
            assign w_rr = w_r[gi+1];
        end
        bdq_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk     (i_clk),
            .i_f_left  (w_fl),
            .i_f_right (w_fr),
            .i_r_left  (w_rl),
            .i_r_right (w_rr),
            .i_data    (i_in.data_value),
            .i_ctl     (w_ctl),
            .i_put_idx (r_cnt),
            .o_f       (w_f[gi]),
            .o_r       (w_r[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // output register with skid: hold a second result while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_take || !r_out_vld) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= w_acc;
                end
            end else if (w_acc) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_res <= r_skid_res;
            end else if (w_acc) begin
                r_out_res <= w_res;
            end
        end else if (w_acc) begin
            r_skid_res <= w_res;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.popped_value = r_out_res.popped_value;
    assign o_out.status       = r_out_res.status;
    assign o_out.entry_count  = r_out_res.entry_count;
    assign o_out.is_empty     = r_out_res.is_empty;
    assign o_out.front_word   = r_out_res.front_word;
    assign o_out.back_word    = r_out_res.back_word;

`ifndef NO_ASSERTIONS
    // the count never runs past the capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("entry count above capacity");

    // a pending skid result implies the output register is occupied
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result while output register is empty");

    // an accepted front push lands its word in cell 0 of the forward row
    a_push_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_kind == KIND_PUSH_FRONT && !w_full)
        |=> (w_f[0] == $past(i_in.data_value)))
        else $error("front push did not reach the head cell");

    // both rows agree on a single stored word
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == ONE_CNT) |-> (w_f[0] == w_r[0]))
        else $error("front and back rows disagree on a single entry");
`endif
endmodule

// ----- tb/sv/tb_bounded_double_ended_queue_top.sv -----
module tb_bounded_double_ended_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    // Shadow deque plus the outcomes still owed by the block, oldest first.
    class deque_checker;
        t_word       shadow_ring [DEPTH];
        int unsigned shadow_head;
        int unsigned shadow_fill;
        t_result     outcomes_due [$];
        int unsigned err_count;

        function new();
            shadow_head = 0;
            shadow_fill = 0;
            err_count   = 0;
        endfunction

        // Apply one accepted operation to the shadow and queue its outcome.
        function void note_op(t_kind op, t_word word);
            t_result want;
            want = '0;
            want.status = ST_DONE;
            if (op == KIND_PUSH_FRONT || op == KIND_PUSH_BACK) begin
                if (shadow_fill >= DEPTH) begin
                    want.status = ST_FULL;
                end else if (op == KIND_PUSH_FRONT) begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_head] = word;
                    shadow_fill++;
                end else begin
                    shadow_ring[(shadow_head + shadow_fill) % DEPTH] = word;
                    shadow_fill++;
                end
            end else begin
                if (shadow_fill == 0) begin
                    want.status = ST_EMPTY;
                end else if (op == KIND_POP_FRONT) begin
                    want.popped_value = shadow_ring[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                end else begin
                    want.popped_value = shadow_ring[(shadow_head + shadow_fill - 1) % DEPTH];
                    shadow_fill--;
                end
            end
            want.entry_count = t_entry'(shadow_fill);
            want.is_empty    = (shadow_fill == 0);
            if (shadow_fill != 0) begin
                want.front_word = shadow_ring[shadow_head];
                want.back_word  = shadow_ring[(shadow_head + shadow_fill - 1) % DEPTH];
            end
            outcomes_due.insert(outcomes_due.size(), want);
        endfunction

        function void match_field(string name, logic signed [WORD_W:0] want_v,
                                  logic signed [WORD_W:0] got_v);
            if (got_v !== want_v) begin
                err_count++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, want_v, got_v);
            end
        endfunction

        // Compare one delivered result against the oldest outcome due.
        function void check_outcome(t_result got);
            t_result want;
            if (outcomes_due.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result: expected none, actual count %0d",
                         $time, got.entry_count);
                return;
            end
            want = outcomes_due[0];
            outcomes_due.delete(0);
            match_field("popped_value", want.popped_value, got.popped_value);
            match_field("status",       want.status,       got.status);
            match_field("entry_count",  want.entry_count,  got.entry_count);
            match_field("is_empty",     want.is_empty,     got.is_empty);
            match_field("front_word",   want.front_word,   got.front_word);
            match_field("back_word",    want.back_word,    got.back_word);
        endfunction

        function int unsigned open_count();
            return outcomes_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdq_in_if  op_if ();
    bdq_out_if res_if ();

    bounded_double_ended_queue_top #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_if),
        .o_out   (res_if)
    );

    deque_checker deque_sb = new();

    // Percent of cycles in which the sender idles / the receiver stalls.
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    // Set while a long receiver hold-off is in progress.
    bit          hold_rx;

    always #5 i_clk = ~i_clk;

    // Drive ready at the falling edge; hold it low for the whole hold-off.
    always @(negedge i_clk) begin
        res_if.ready <= !hold_rx && ($urandom_range(99) >= sink_stall_pct);
    end

    // Check each result transaction at the rising edge it is accepted on.
    always @(posedge i_clk) begin : result_check
        t_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.popped_value = res_if.popped_value;
            got.status       = res_if.status;
            got.entry_count  = res_if.entry_count;
            got.is_empty     = res_if.is_empty;
            got.front_word   = res_if.front_word;
            got.back_word    = res_if.back_word;
            deque_sb.check_outcome(got);
        end
    end

    // Offer one operation, idling first at the current rate; return at the
    // falling edge after the transaction, with valid still high so that
    // back-to-back operations need no gap.
    task automatic send_op(t_kind op, t_word word);
        while ($urandom_range(99) < src_idle_pct) begin
            op_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        op_if.valid      <= 1'b1;
        op_if.kind       <= op;
        op_if.data_value <= word;
        do @(posedge i_clk); while (!(op_if.valid && op_if.ready));
        deque_sb.note_op(op, word);
        @(negedge i_clk);
    endtask

    // Mostly random words, with the extremes mixed in now and then.
    function automatic t_word rand_word();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_kind rand_op(int unsigned push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        return $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
    endfunction

    // Count out the long receiver hold-off in its own process.
    task automatic hold_receiver(int unsigned cycles);
        hold_rx = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_rx = 1'b0;
    endtask

    // Random operations in runs: push-heavy runs drive the queue to full,
    // pop-heavy runs drain it to empty, balanced runs stir the middle.
    task automatic run_segments(int unsigned n_items);
        int unsigned sent;
        int unsigned push_pct;
        int unsigned seg_len;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            seg_len = $urandom_range(100, 20);
            repeat (seg_len) begin
                if (sent >= n_items) break;
                send_op(rand_op(push_pct), rand_word());
                sent++;
            end
        end
    endtask

    initial begin
        op_if.valid      = 1'b0;
        op_if.kind       = KIND_PUSH_FRONT;
        op_if.data_value = '0;
        res_if.ready     = 1'b0;
        i_rst_n          = 1'b0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        hold_rx          = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: pops on an empty queue, extreme words at both ends,
        // every operation, and a drain back past empty.
        send_op(KIND_POP_FRONT,  '0);
        send_op(KIND_POP_BACK,   32'sh7FFF_FFFF);
        send_op(KIND_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_op(KIND_PUSH_BACK,  32'sh8000_0000);
        send_op(KIND_PUSH_FRONT, '0);
        send_op(KIND_PUSH_BACK,  -32'sd1);
        send_op(KIND_POP_BACK,   '0);
        send_op(KIND_POP_FRONT,  -32'sd1);
        send_op(KIND_POP_FRONT,  '0);
        send_op(KIND_POP_BACK,   '0);
        send_op(KIND_POP_BACK,   '0);
        send_op(KIND_PUSH_BACK,  32'sh5555_5555);
        send_op(KIND_PUSH_FRONT, 32'shAAAA_AAAA);
        send_op(KIND_POP_FRONT,  '0);
        send_op(KIND_POP_BACK,   '0);

        // Fill past full with random pushes, so refused pushes show up,
        // then drain past empty with random pops.
        repeat (DEPTH + 6) send_op(rand_op(100), rand_word());
        repeat (DEPTH + 6) send_op(rand_op(0), rand_word());

        // Stall the receiver for a long stretch while the sender keeps
        // offering, so the result registers fill and the input backs up.
        fork
            hold_receiver(80);
        join_none
        run_segments(150);

        // Sweep the idle/stall mixes: none, sender only, receiver only, both.
        run_segments(150);
        src_idle_pct = 59;
        run_segments(280);
        src_idle_pct   = 0;
        sink_stall_pct = 59;
        run_segments(280);
        src_idle_pct   = 29;
        sink_stall_pct = 29;
        run_segments(280);

        // Stop offering, open the receiver and let the results drain.
        op_if.valid    <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        while (deque_sb.open_count() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (deque_sb.err_count == 0 && deque_sb.open_count() == 0) begin
            $display("tb_bounded_double_ended_queue_top: done, clean");
        end else begin
            $display("tb_bounded_double_ended_queue_top: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d results outstanding", $time,
                 deque_sb.open_count());
        $display("tb_bounded_double_ended_queue_top: done, errors");
        $finish;
    end

endmodule

// ----- bounded_double_ended_queue_top.f -----
design/bdq_pkg.sv
design/bdq_in_if.sv
design/bdq_out_if.sv
design/bdq_cell.sv
design/bounded_double_ended_queue_top.sv
tb/sv/tb_bounded_double_ended_queue_top.sv
